// ----- rtl/oalr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oalr_pkg
// Shared types and constants for the occlusion aware line rmse matcher.
// ----------------------------------------------------------------------------
package oalr_pkg;

  localparam int FRAC_BITS = 8;

  localparam int ERR_W  = 48;
  localparam int LINE_W = 11;
  localparam int SEEN_W = 12;
  localparam int DROP_W = 11;
  localparam int MAG_W  = 16;
  localparam int PROD_W = 2 * MAG_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // status codes of one side of a line
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_VALUE   = 2'd2;

  // result when no line entered the mean: 100.0, saturated to 16 bits
  localparam longint RMS_RAW = longint'(100) << FRAC_BITS;
  localparam logic [15:0] RMS_EMPTY = (RMS_RAW > 65535) ? 16'hFFFF : 16'(RMS_RAW);

  typedef struct packed {
    logic signed [15:0] range_a;
    logic [1:0]         state_a;
    logic signed [15:0] range_b;
    logic [1:0]         state_b;
    logic [15:0]        line_len;
    logic               last_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rms_error;
    logic [16:0] known_fraction;
  } out_item_t;

  // classified line, as queued between front and back
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             add_err;
    logic             cnt_line;
    logic [1:0]       seen_n;
    logic             drop;
    logic             last;
  } line_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/oalr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oalr_front
// Takes line transactions and sorts them by the occlusion rules into
// queue entries.
// ----------------------------------------------------------------------------
module oalr_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  oalr_pkg::in_item_t   in_data,
  input  oalr_pkg::q_status_t  q_st,
  output logic                 q_push,
  output oalr_pkg::line_op_t   q_wdata
);

  logic signed [16:0] diff;
  logic               neg;
  logic               pos;
  logic [16:0]        abs_diff;
  logic [1:0]         sa;
  logic [1:0]         sb;

  assign in_stall = q_st.full;
  assign q_push   = in_valid && !q_st.full;

  assign sa       = in_data.state_a;
  assign sb       = in_data.state_b;
  assign diff     = 17'({in_data.range_a[15], in_data.range_a}) -
                    17'({in_data.range_b[15], in_data.range_b});
  assign neg      = diff[16];
  assign pos      = !neg && (diff != 17'sd0);
  assign abs_diff = neg ? 17'(-diff) : 17'(diff);

  always_comb begin
    q_wdata          = '0;
    q_wdata.last     = in_data.last_line;
    q_wdata.mag      = abs_diff[15:0];
    priority if (sa == oalr_pkg::ST_UNKNOWN && sb == oalr_pkg::ST_VALUE) begin
      q_wdata.seen_n   = 2'd1;
      q_wdata.add_err  = neg;
      q_wdata.cnt_line = neg;
      q_wdata.drop     = !neg;
    end else if (sb == oalr_pkg::ST_UNKNOWN && sa == oalr_pkg::ST_VALUE) begin
      q_wdata.seen_n   = 2'd1;
      q_wdata.add_err  = pos;
      q_wdata.cnt_line = pos;
      q_wdata.drop     = !pos;
    end else if ((sa == oalr_pkg::ST_VALUE && sb == oalr_pkg::ST_EMPTY) ||
                 (sa == oalr_pkg::ST_EMPTY && sb == oalr_pkg::ST_VALUE)) begin
      q_wdata.mag      = in_data.line_len;
      q_wdata.add_err  = 1'b1;
      q_wdata.cnt_line = 1'b1;
      q_wdata.seen_n   = 2'd1;
    end else if (sa == oalr_pkg::ST_EMPTY && sb == oalr_pkg::ST_EMPTY) begin
      q_wdata.cnt_line = 1'b1;
    end else if (sa == oalr_pkg::ST_VALUE && sb == oalr_pkg::ST_VALUE) begin
      q_wdata.add_err  = 1'b1;
      q_wdata.cnt_line = 1'b1;
      q_wdata.seen_n   = 2'd2;
    end else begin
      // ignored pair: only the last mark travels on
      q_wdata.mag      = '0;
    end
  end

endmodule

// ----- rtl/oalr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oalr_queue
// Short first-in first-out queue of classified lines between front and back.
// ----------------------------------------------------------------------------
module oalr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  oalr_pkg::line_op_t  wdata,
  input  logic                pop,
  output oalr_pkg::line_op_t  rdata,
  output oalr_pkg::q_status_t status
);

  oalr_pkg::line_op_t         ent_r [oalr_pkg::Q_DEPTH];
  logic [oalr_pkg::Q_AW-1:0]  wr_ptr_r;
  logic [oalr_pkg::Q_AW-1:0]  rd_ptr_r;
  logic [oalr_pkg::Q_AW:0]    count_r;
  logic [oalr_pkg::Q_AW:0]    count_nxt;

  assign status.full  = (count_r == (oalr_pkg::Q_AW + 1)'(oalr_pkg::Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/oalr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oalr_back
// Squares and accumulates queued lines; on the last line runs the serial
// divides and square root and holds the result for the output channel.
// ----------------------------------------------------------------------------
module oalr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  oalr_pkg::q_status_t q_st,
  input  oalr_pkg::line_op_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output oalr_pkg::out_item_t out_data
);

  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_FLOAD = 3'd4;
  localparam logic [2:0] S_FRAC  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int DIV_STEPS  = oalr_pkg::ERR_W;
  localparam int SQRT_STEPS = oalr_pkg::ERR_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int DEN_W      = oalr_pkg::SEEN_W;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = ROOT_W + 1;

  logic [2:0]                   st_r;

  // square stage
  logic                         p_vld_r;
  oalr_pkg::line_op_t           p_op_r;
  logic [oalr_pkg::PROD_W-1:0]  prod_r;

  // accumulators
  logic [oalr_pkg::ERR_W-1:0]   err_r;
  logic [oalr_pkg::LINE_W-1:0]  lines_r;
  logic [oalr_pkg::SEEN_W-1:0]  seen_r;
  logic [oalr_pkg::DROP_W-1:0]  drop_r;
  logic [oalr_pkg::ERR_W:0]     err_sum;
  logic [oalr_pkg::SEEN_W:0]    seen_sum;
  logic [oalr_pkg::ERR_W-1:0]   err_nxt;
  logic [oalr_pkg::LINE_W-1:0]  lines_nxt;
  logic [oalr_pkg::SEEN_W-1:0]  seen_nxt;
  logic [oalr_pkg::DROP_W-1:0]  drop_nxt;

  // shared restoring divider
  logic [oalr_pkg::ERR_W-1:0]   dv_num_r;
  logic [DEN_W-1:0]             dv_den_r;
  logic [DEN_W-1:0]             dv_rem_r;
  logic [DEN_W:0]               dv_sh;
  logic                         dv_ge;
  logic [DEN_W:0]               dv_sub;
  logic [oalr_pkg::ERR_W-1:0]   dv_num_nxt;
  logic [CNT_W-1:0]             cnt_r;

  // digit-by-digit square root
  logic [oalr_pkg::ERR_W-1:0]   sq_val_r;
  logic [SREM_W-1:0]            sq_rem_r;
  logic [ROOT_W-1:0]            sq_root_r;
  logic [SREM_W+1:0]            sq_sh;
  logic [SREM_W+1:0]            sq_trial;
  logic                         sq_ge;
  logic [SREM_W+1:0]            sq_sub;
  logic [ROOT_W-1:0]            sq_root_nxt;

  logic [oalr_pkg::SEEN_W-1:0]  kept;

  logic [15:0]                  rms_r;
  logic [16:0]                  frac_r;

  assign q_pop = (st_r == S_RUN) && !q_st.empty && !(p_vld_r && p_op_r.last);

  assign out_valid               = (st_r == S_OUT);
  assign out_data.rms_error      = rms_r;
  assign out_data.known_fraction = frac_r;

  // accumulate with saturation
  always_comb begin
    err_sum   = {1'b0, err_r} +
                (p_op_r.add_err ? (oalr_pkg::ERR_W + 1)'(prod_r) : '0);
    err_nxt   = err_sum[oalr_pkg::ERR_W] ? '1 : err_sum[oalr_pkg::ERR_W-1:0];
    seen_sum  = {1'b0, seen_r} + (oalr_pkg::SEEN_W + 1)'(p_op_r.seen_n);
    seen_nxt  = seen_sum[oalr_pkg::SEEN_W] ? '1 : seen_sum[oalr_pkg::SEEN_W-1:0];
    lines_nxt = (p_op_r.cnt_line && !(&lines_r)) ? lines_r + 1'b1 : lines_r;
    drop_nxt  = (p_op_r.drop && !(&drop_r)) ? drop_r + 1'b1 : drop_r;
  end

  always_comb begin
    dv_sh      = {dv_rem_r, dv_num_r[oalr_pkg::ERR_W-1]};
    dv_ge      = (dv_sh >= {1'b0, dv_den_r});
    dv_sub     = dv_sh - {1'b0, dv_den_r};
    dv_num_nxt = {dv_num_r[oalr_pkg::ERR_W-2:0], dv_ge};
  end

  always_comb begin
    sq_sh       = {sq_rem_r, sq_val_r[oalr_pkg::ERR_W-1 -: 2]};
    sq_trial    = {1'b0, sq_root_r, 2'b01};
    sq_ge       = (sq_sh >= sq_trial);
    sq_sub      = sq_sh - sq_trial;
    sq_root_nxt = {sq_root_r[ROOT_W-2:0], sq_ge};
  end

  assign kept = (oalr_pkg::SEEN_W)'(drop_r) > seen_r ? '0 :
                seen_r - (oalr_pkg::SEEN_W)'(drop_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_RUN;
      p_vld_r <= 1'b0;
      err_r   <= '0;
      lines_r <= '0;
      seen_r  <= '0;
      drop_r  <= '0;
    end else begin
      p_vld_r <= q_pop;
      unique case (st_r)
        S_RUN: begin
          if (p_vld_r) begin
            err_r   <= err_nxt;
            lines_r <= lines_nxt;
            seen_r  <= seen_nxt;
            drop_r  <= drop_nxt;
            if (p_op_r.last) begin
              st_r <= S_START;
            end
          end
        end
        S_START: begin
          st_r <= (lines_r == '0) ? S_FLOAD : S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            st_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
            st_r <= S_FLOAD;
          end
        end
        S_FLOAD: begin
          st_r <= (seen_r == '0) ? S_OUT : S_FRAC;
        end
        S_FRAC: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            err_r   <= '0;
            lines_r <= '0;
            seen_r  <= '0;
            drop_r  <= '0;
            st_r    <= S_RUN;
          end
        end
        default: begin
          st_r <= S_RUN;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_op_r <= q_rdata;
      prod_r <= q_rdata.mag * q_rdata.mag;
    end
    unique case (st_r)
      S_START: begin
        cnt_r    <= '0;
        dv_num_r <= err_r;
        dv_den_r <= DEN_W'(lines_r);
        dv_rem_r <= '0;
        if (lines_r == '0) begin
          rms_r <= oalr_pkg::RMS_EMPTY;
        end
      end
      S_DIV: begin
        dv_num_r <= dv_num_nxt;
        dv_rem_r <= dv_ge ? dv_sub[DEN_W-1:0] : dv_sh[DEN_W-1:0];
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_r     <= '0;
          sq_val_r  <= dv_num_nxt;
          sq_rem_r  <= '0;
          sq_root_r <= '0;
        end else begin
          cnt_r     <= cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cnt_r     <= cnt_r + 1'b1;
        sq_val_r  <= {sq_val_r[oalr_pkg::ERR_W-3:0], 2'b00};
        sq_rem_r  <= sq_ge ? sq_sub[SREM_W-1:0] : sq_sh[SREM_W-1:0];
        sq_root_r <= sq_root_nxt;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          rms_r <= (sq_root_nxt > ROOT_W'(16'hFFFF)) ? 16'hFFFF : sq_root_nxt[15:0];
        end
      end
      S_FLOAD: begin
        cnt_r    <= '0;
        dv_num_r <= oalr_pkg::ERR_W'({kept, 16'h0000});
        dv_den_r <= seen_r;
        dv_rem_r <= '0;
        if (seen_r == '0) begin
          frac_r <= '0;
        end
      end
      S_FRAC: begin
        cnt_r    <= cnt_r + 1'b1;
        dv_num_r <= dv_num_nxt;
        dv_rem_r <= dv_ge ? dv_sub[DEN_W-1:0] : dv_sh[DEN_W-1:0];
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          frac_r <= dv_num_nxt[16:0];
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

// ----- rtl/occlusion_aware_line_rmse_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occlusion_aware_line_rmse_top
// Line pair matcher: accumulates occlusion aware squared error over an image
// pair and returns the rms error and known point fraction on the last line.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_stall  | in_data  (oalr_pkg::in_item_t)
//  out      | out_valid / out_stall| out_data (oalr_pkg::out_item_t)
//
//  the front takes one line per cycle while the 4-entry queue has room;
//  in its run state the back retires one queued line per cycle (square, then
//  accumulate); a last line then runs a 48-step divide, 24-step square root
//  and 48-step fraction divide, with load states between; the divide and
//  root are skipped when no line was counted, the fraction when no point.
//  rst_n is synchronous and clears the queue, sequencer and accumulators.
//  out_stall holds the result; the front keeps filling the queue meanwhile.
module occlusion_aware_line_rmse_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oalr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output oalr_pkg::out_item_t out_data
);

  oalr_pkg::q_status_t q_st;
  oalr_pkg::line_op_t  q_wdata;
  oalr_pkg::line_op_t  q_rdata;
  logic                q_push;
  logic                q_pop;

  oalr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_st     (q_st),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  oalr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_st)
  );

  oalr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("queue popped while empty");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.known_fraction <= 17'h10000))
    else $error("known fraction above one");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

// ----- bench/occlusion_aware_line_rmse_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occlusion_aware_line_rmse_top_test
// Streams line pairs of image pairs into the matcher and checks every
// rms error / known fraction result against a line-by-line accumulator
// model, under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------

class rmse_scoreboard;
  logic [oalr_pkg::ERR_W-1:0]  err_acc;
  logic [oalr_pkg::LINE_W-1:0] lines_cnt;
  logic [oalr_pkg::SEEN_W-1:0] seen_cnt;
  logic [oalr_pkg::DROP_W-1:0] drop_cnt;
  oalr_pkg::out_item_t         expected_q[$];
  int                          mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    err_acc   = '0;
    lines_cnt = '0;
    seen_cnt  = '0;
    drop_cnt  = '0;
  endfunction

  function void add_err(longint unsigned sq);
    longint unsigned s;
    s = longint'(err_acc) + sq;
    err_acc = (s > {oalr_pkg::ERR_W{1'b1}}) ? {oalr_pkg::ERR_W{1'b1}} :
              s[oalr_pkg::ERR_W-1:0];
  endfunction

  function void bump_line();
    if (lines_cnt != {oalr_pkg::LINE_W{1'b1}}) lines_cnt++;
  endfunction

  function void add_seen(int n);
    int s;
    s = int'(seen_cnt) + n;
    seen_cnt = (s > int'({oalr_pkg::SEEN_W{1'b1}})) ? {oalr_pkg::SEEN_W{1'b1}} :
               s[oalr_pkg::SEEN_W-1:0];
  endfunction

  function void bump_drop();
    if (drop_cnt != {oalr_pkg::DROP_W{1'b1}}) drop_cnt++;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned trial;
    res = 0;
    for (int i = 24; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // one accepted line transaction
  function void note_line(oalr_pkg::in_item_t t);
    longint              a;
    longint              b;
    longint              d;
    longint unsigned     sq;
    longint unsigned     len_sq;
    longint unsigned     rms;
    longint unsigned     kept;
    longint unsigned     frac;
    oalr_pkg::out_item_t exp_item;
    a = longint'(t.range_a);
    b = longint'(t.range_b);
    d = (a > b) ? a - b : b - a;
    sq = longint'(d) * longint'(d);
    len_sq = longint'(t.line_len) * longint'(t.line_len);

    if (t.state_a == oalr_pkg::ST_UNKNOWN && t.state_b == oalr_pkg::ST_VALUE) begin
      add_seen(1);
      if (b > a) begin
        add_err(sq);
        bump_line();
      end else begin
        bump_drop();
      end
    end else if (t.state_b == oalr_pkg::ST_UNKNOWN && t.state_a == oalr_pkg::ST_VALUE) begin
      add_seen(1);
      if (a > b) begin
        add_err(sq);
        bump_line();
      end else begin
        bump_drop();
      end
    end else if ((t.state_a == oalr_pkg::ST_VALUE && t.state_b == oalr_pkg::ST_EMPTY) ||
                 (t.state_a == oalr_pkg::ST_EMPTY && t.state_b == oalr_pkg::ST_VALUE)) begin
      add_err(len_sq);
      bump_line();
      add_seen(1);
    end else if (t.state_a == oalr_pkg::ST_EMPTY && t.state_b == oalr_pkg::ST_EMPTY) begin
      bump_line();
    end else if (t.state_a == oalr_pkg::ST_VALUE && t.state_b == oalr_pkg::ST_VALUE) begin
      add_err(sq);
      bump_line();
      add_seen(2);
    end

    if (t.last_line) begin
      if (lines_cnt == 0) rms = 64'd100 << oalr_pkg::FRAC_BITS;
      else rms = int_sqrt(longint'(err_acc) / longint'(lines_cnt));
      if (rms > 64'hFFFF) rms = 64'hFFFF;
      if (seen_cnt == 0) begin
        frac = 0;
      end else begin
        kept = (drop_cnt > seen_cnt) ? 0 : longint'(seen_cnt) - longint'(drop_cnt);
        frac = (kept << 16) / longint'(seen_cnt);
      end
      exp_item.rms_error      = rms[15:0];
      exp_item.known_fraction = frac[16:0];
      expected_q.push_back(exp_item);
      clear();
    end
  endfunction

  function void check_result(oalr_pkg::out_item_t got);
    oalr_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: rms %0d frac %0d", got.rms_error, got.known_fraction);
      return;
    end
    want = expected_q.pop_front();
    if (got.rms_error !== want.rms_error || got.known_fraction !== want.known_fraction) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: rms exp %0d got %0d, frac exp %0d got %0d",
                 want.rms_error, got.rms_error, want.known_fraction, got.known_fraction);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module occlusion_aware_line_rmse_top_test;

  localparam logic [1:0] ST_UNKNOWN   = oalr_pkg::ST_UNKNOWN;
  localparam logic [1:0] ST_EMPTY     = oalr_pkg::ST_EMPTY;
  localparam logic [1:0] ST_VALUE     = oalr_pkg::ST_VALUE;
  localparam logic [1:0] ST_IGNORED   = 2'd3;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         WATCHDOG     = 5000;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         LONG_HALF    = 100;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  oalr_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  oalr_pkg::out_item_t out_data;

  rmse_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_lines_sent  = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  occlusion_aware_line_rmse_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // result side: stall decision at the falling edge, check at the rising edge
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic oalr_pkg::in_item_t mk_line(logic signed [15:0] a, logic [1:0] st_a,
                                                 logic signed [15:0] b, logic [1:0] st_b,
                                                 logic [15:0] len, logic last);
    oalr_pkg::in_item_t t;
    t.range_a   = a;
    t.state_a   = st_a;
    t.range_b   = b;
    t.state_b   = st_b;
    t.line_len  = len;
    t.last_line = last;
    return t;
  endfunction

  function automatic logic [1:0] pick_state();
    int r;
    r = $urandom_range(99);
    if (r < 55) return ST_VALUE;
    else if (r < 70) return ST_UNKNOWN;
    else if (r < 88) return ST_EMPTY;
    else return ST_IGNORED;
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 16'h7FFF;
    else if (r < 12) return 16'h8000;
    else if (r < 16) return 16'h0000;
    else if (r < 20) return 16'hFFFF;
    else return 16'($urandom_range(65535));
  endfunction

  task automatic send_line(input oalr_pkg::in_item_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_line(t);
    n_lines_sent++;
  endtask

  task automatic run_image();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(6, 1);
    else if (r < 95) n = $urandom_range(30, 7);
    else n = $urandom_range(120, 31);
    for (int i = 0; i < n; i++)
      send_line(mk_line(pick_word(), pick_state(), pick_word(), pick_state(),
                        pick_word(), i == n - 1));
  endtask

  // long image: a run of hidden points, then a run of compared lines
  task automatic run_long_image();
    logic [15:0] x;
    logic [15:0] y;
    for (int i = 0; i < LONG_HALF; i++) begin
      x = pick_word();
      y = pick_word();
      if ($signed(x) >= $signed(y))
        send_line(mk_line(x, ST_UNKNOWN, y, ST_VALUE, pick_word(), 1'b0));
      else
        send_line(mk_line(y, ST_UNKNOWN, x, ST_VALUE, pick_word(), 1'b0));
    end
    for (int i = 0; i < LONG_HALF; i++)
      send_line(mk_line(pick_word(), ST_VALUE, pick_word(), ST_VALUE, pick_word(),
                        i == LONG_HALF - 1));
  endtask

  initial begin
    oalr_pkg::in_item_t directed_q[$];
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 79;

    // one image touching every line class, extremes of ranges and length
    directed_q.push_back(mk_line(16'sh7FFF, ST_VALUE, 16'sh8000, ST_VALUE, 16'h0000, 1'b0));
    directed_q.push_back(mk_line(16'sh8000, ST_VALUE, 16'sh7FFF, ST_VALUE, 16'h0001, 1'b0));
    directed_q.push_back(mk_line(16'sh8000, ST_UNKNOWN, 16'sh7FFF, ST_VALUE, 16'h1234, 1'b0));
    directed_q.push_back(mk_line(16'sh0005, ST_UNKNOWN, 16'sh0005, ST_VALUE, 16'h0100, 1'b0));
    directed_q.push_back(mk_line(16'sh0300, ST_VALUE, 16'shFF00, ST_UNKNOWN, 16'h0000, 1'b0));
    directed_q.push_back(mk_line(16'shFF00, ST_VALUE, 16'sh0300, ST_UNKNOWN, 16'hFFFF, 1'b0));
    directed_q.push_back(mk_line(16'sh0000, ST_EMPTY, 16'sh1000, ST_VALUE, 16'hFFFF, 1'b0));
    directed_q.push_back(mk_line(16'sh1000, ST_VALUE, 16'sh0000, ST_EMPTY, 16'hFFFF, 1'b0));
    directed_q.push_back(mk_line(16'sh0000, ST_EMPTY, 16'sh0000, ST_EMPTY, 16'h0200, 1'b0));
    directed_q.push_back(mk_line(16'sh7FFF, ST_IGNORED, 16'sh8000, ST_VALUE, 16'hFFFF, 1'b0));
    directed_q.push_back(mk_line(16'sh7FFF, ST_UNKNOWN, 16'sh8000, ST_UNKNOWN, 16'h0100, 1'b0));
    directed_q.push_back(mk_line(16'sh0100, ST_UNKNOWN, 16'sh0200, ST_EMPTY, 16'h0100, 1'b0));
    directed_q.push_back(mk_line(16'sh0100, ST_EMPTY, 16'sh0200, ST_UNKNOWN, 16'h0100, 1'b1));
    // image with only ignored lines: no counted line, no point
    directed_q.push_back(mk_line(16'sh0100, ST_VALUE, 16'sh0200, ST_IGNORED, 16'h0100, 1'b0));
    directed_q.push_back(mk_line(16'sh0100, ST_IGNORED, 16'sh0200, ST_IGNORED, 16'hFFFF, 1'b1));
    // counted line with zero error, no point
    directed_q.push_back(mk_line(16'sh0000, ST_EMPTY, 16'sh0000, ST_EMPTY, 16'hFFFF, 1'b1));
    // only a dropped point: no counted line, nothing kept
    directed_q.push_back(mk_line(16'sh7FFF, ST_UNKNOWN, 16'sh8000, ST_VALUE, 16'h0000, 1'b1));
    // identical values: zero error, every point kept
    directed_q.push_back(mk_line(16'sh1234, ST_VALUE, 16'sh1234, ST_VALUE, 16'h0000, 1'b1));
    directed_q.push_back(mk_line(16'sh0180, ST_VALUE, 16'sh0100, ST_VALUE, 16'h0080, 1'b0));
    directed_q.push_back(mk_line(16'sh0100, ST_UNKNOWN, 16'sh0080, ST_VALUE, 16'h0080, 1'b1));
    foreach (directed_q[i]) send_line(directed_q[i]);

    while (n_lines_sent < 350) run_image();

    send_idle_pct = 79;
    recv_idle_pct = 14;
    while (n_lines_sent < 700) run_image();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    while (n_lines_sent < 800) run_image();
    run_long_image();

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
